### rtl/rhh_pkg.sv
// Shared types and constants for the Robin Hood hash table.
// Holds table geometry, request and response codes, and the
// controller/datapath command and status structs. No dependencies.
package rhh_pkg;

	// Table geometry
	localparam int TABLE_ENTRIES = 1024;
	localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = SLOT_W + 1;
	localparam int LIM_W         = 11;
	localparam int CMP_W         = (CNT_W > LIM_W) ? CNT_W : LIM_W;
	localparam int KEY_W         = 64;
	localparam int VAL_W         = 64;

	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(768);

	// Request kinds
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_ERASE  = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	// Response codes
	localparam logic [2:0] RSP_INSERTED = 3'd0;
	localparam logic [2:0] RSP_UPDATED  = 3'd1;
	localparam logic [2:0] RSP_FOUND    = 3'd2;
	localparam logic [2:0] RSP_ABSENT   = 3'd3;
	localparam logic [2:0] RSP_ERASED   = 3'd4;
	localparam logic [2:0] RSP_FULL     = 3'd5;

	// One table slot as stored in memory
	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] pdist;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic       load_req;
		logic       init_walk;
		logic       step_clr;
		logic       mem_rd;
		logic       rd_next;
		logic       walk_adv;
		logic       upd_wr;
		logic       set_found;
		logic       place_new;
		logic       place_swap;
		logic       shift_move;
		logic       shift_clear;
		logic       out_load;
		logic [2:0] out_status;
	} rhh_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic       clr_busy;
		logic       hash_done;
		logic [1:0] kind;
		logic       rd_valid;
		logic       key_eq;
		logic       dist_lt;
		logic       dist_zero;
		logic       step_full;
		logic       step_last;
		logic       at_limit;
		logic       out_busy;
	} rhh_sts_t;

endpackage

### rtl/rhh_hash.sv
// XXH64 (seed 0) of one 8-byte key, reduced to a home slot.
// Five 64-bit multiplies, in turn, on one shared 32x32 multiplier.
// Depends on rhh_pkg.
module rhh_hash (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [63:0]               key,
	output logic                      done,
	output logic [rhh_pkg::SLOT_W-1:0] home
);

	localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
	localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;
	localparam logic [63:0] SEED_H = PR5 + 64'd8;
	localparam logic [2:0]  M_LAST = 3'd4;

	logic        busy_q, fin_q;
	logic [2:0]  m_q;
	logic [1:0]  ph_q;
	logic [63:0] acc_q, a_q;
	logic [63:0] prep, bconst, t4, t2;
	logic [31:0] mul_x, mul_y;
	logic [63:0] prod;

	// Operand for the next multiply, from the running value
	always_comb begin
		t4 = acc_q + PR4;
		t2 = SEED_H ^ acc_q;
		unique case (m_q)
			3'd0: prep = acc_q;
			3'd1: prep = {acc_q[32:0], acc_q[63:33]};
			3'd2: prep = {t2[36:0], t2[63:37]};
			3'd3: prep = t4 ^ (t4 >> 33);
			3'd4: prep = acc_q ^ (acc_q >> 29);
			default: prep = acc_q;
		endcase
		unique case (m_q)
			3'd0: bconst = PR2;
			3'd1: bconst = PR1;
			3'd2: bconst = PR1;
			3'd3: bconst = PR2;
			3'd4: bconst = PR3;
			default: bconst = PR1;
		endcase
	end

	// Partial products: lo*lo, then the two cross terms (low halves only)
	always_comb begin
		case (ph_q)
			2'd2: begin
				mul_x = a_q[31:0];
				mul_y = bconst[63:32];
			end
			2'd3: begin
				mul_x = a_q[63:32];
				mul_y = bconst[31:0];
			end
			default: begin
				mul_x = a_q[31:0];
				mul_y = bconst[31:0];
			end
		endcase
		prod = {32'b0, mul_x} * {32'b0, mul_y};
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			m_q    <= '0;
			ph_q   <= '0;
		end else begin
			fin_q <= busy_q && (ph_q == 2'd3) && (m_q == M_LAST);
			if (start) begin
				busy_q <= 1'b1;
				m_q    <= '0;
				ph_q   <= '0;
			end else if (busy_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd3) begin
					if (m_q == M_LAST)
						busy_q <= 1'b0;
					else
						m_q <= m_q + 3'd1;
				end
			end
		end
	end

	// Running value and latched operand
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= key;
		end else if (busy_q) begin
			case (ph_q)
				2'd0: a_q <= prep;
				2'd1: acc_q <= prod;
				default: acc_q <= acc_q + {prod[31:0], 32'b0};
			endcase
		end
	end

	// Final fold h ^ (h >> 32), low bits only
	assign home = acc_q[rhh_pkg::SLOT_W-1:0] ^ acc_q[32 +: rhh_pkg::SLOT_W];
	assign done = fin_q;

endmodule

### rtl/rhh_datapath.sv
// Datapath: request registers, hash unit, slot memory, walk registers,
// entry counter, limit register and the result register.
// Depends on rhh_pkg and rhh_hash.
module rhh_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rhh_pkg::rhh_cmd_t          cmd,
	output rhh_pkg::rhh_sts_t          sts,
	input  logic [1:0]                 in_kind,
	input  logic [rhh_pkg::KEY_W-1:0]  in_key,
	input  logic [rhh_pkg::VAL_W-1:0]  in_value,
	input  logic                       cfg_wr,
	input  logic [rhh_pkg::LIM_W-1:0]  cfg_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 out_status,
	output logic [rhh_pkg::VAL_W-1:0]  out_found,
	output logic [rhh_pkg::LIM_W-1:0]  out_count
);

	localparam int SW = rhh_pkg::SLOT_W;
	localparam int CW = rhh_pkg::CNT_W;

	rhh_pkg::entry_t mem [rhh_pkg::TABLE_ENTRIES];
	rhh_pkg::entry_t rd_q, wr_data;
	logic            wr_en;
	logic [SW-1:0]   wr_addr, rd_addr;

	logic [1:0]              kind_q;
	logic [rhh_pkg::KEY_W-1:0] key_q, car_key_q;
	logic [rhh_pkg::VAL_W-1:0] value_q, car_val_q, found_q;
	logic [SW-1:0]           pos_q, d_q, clr_addr_q;
	logic [CW-1:0]           step_q, count_q;
	logic [rhh_pkg::LIM_W-1:0] limit_q;
	logic                    clr_busy_q, out_valid_q;
	logic [2:0]              out_status_q;
	logic [rhh_pkg::VAL_W-1:0] out_found_q;
	logic [rhh_pkg::LIM_W-1:0] out_count_q;

	logic          hash_done;
	logic [SW-1:0] home;

	rhh_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load_req),
		.key    (in_key),
		.done   (hash_done),
		.home   (home)
	);

	// Memory write select; the clearing pass owns the port after reset
	always_comb begin
		wr_en   = 1'b1;
		wr_addr = pos_q;
		wr_data = '0;
		if (clr_busy_q) begin
			wr_addr = clr_addr_q;
		end else if (cmd.upd_wr) begin
			wr_data = '{valid: 1'b1, pdist: rd_q.pdist, key: rd_q.key, value: value_q};
		end else if (cmd.place_new || cmd.place_swap) begin
			wr_data = '{valid: 1'b1, pdist: d_q, key: car_key_q, value: car_val_q};
		end else if (cmd.shift_move) begin
			wr_data = '{valid: 1'b1, pdist: rd_q.pdist - SW'(1), key: rd_q.key,
				value: rd_q.value};
		end else if (!cmd.shift_clear) begin
			wr_en = 1'b0;
		end
	end

	assign rd_addr = cmd.rd_next ? pos_q + SW'(1) : pos_q;

	// Slot memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.mem_rd)
			rd_q <= mem[rd_addr];
	end

	// Clearing pass and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			count_q     <= '0;
			limit_q     <= rhh_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + SW'(1);
				if (clr_addr_q == SW'(rhh_pkg::TABLE_ENTRIES - 1))
					clr_busy_q <= 1'b0;
			end
			if (cfg_wr)
				limit_q <= cfg_data;
			if (cmd.place_new)
				count_q <= count_q + CW'(1);
			else if (cmd.shift_clear && count_q != '0)
				count_q <= count_q - CW'(1);
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Request, walk and result payload
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q  <= in_kind;
			key_q   <= in_key;
			value_q <= in_value;
			found_q <= '0;
		end else if (cmd.set_found) begin
			found_q <= rd_q.value;
		end
		if (cmd.init_walk) begin
			pos_q     <= home;
			d_q       <= '0;
			step_q    <= '0;
			car_key_q <= key_q;
			car_val_q <= value_q;
		end else begin
			if (cmd.step_clr)
				step_q <= '0;
			if (cmd.walk_adv || cmd.place_swap || cmd.shift_move) begin
				pos_q  <= pos_q + SW'(1);
				step_q <= step_q + CW'(1);
			end
			if (cmd.walk_adv)
				d_q <= d_q + SW'(1);
			if (cmd.place_swap) begin
				d_q       <= rd_q.pdist + SW'(1);
				car_key_q <= rd_q.key;
				car_val_q <= rd_q.value;
			end
		end
		if (cmd.out_load) begin
			out_status_q <= cmd.out_status;
			out_found_q  <= found_q;
			out_count_q  <= rhh_pkg::LIM_W'(count_q);
		end
	end

	// Status to the controller
	always_comb begin
		sts.clr_busy  = clr_busy_q;
		sts.hash_done = hash_done;
		sts.kind      = kind_q;
		sts.rd_valid  = rd_q.valid;
		sts.key_eq    = rd_q.key == key_q;
		sts.dist_lt   = d_q > rd_q.pdist;
		sts.dist_zero = rd_q.pdist == '0;
		sts.step_full = step_q == CW'(rhh_pkg::TABLE_ENTRIES);
		sts.step_last = step_q == CW'(rhh_pkg::TABLE_ENTRIES - 1);
		sts.at_limit  = (rhh_pkg::CMP_W'(count_q) >= rhh_pkg::CMP_W'(limit_q)) ||
			(count_q >= CW'(rhh_pkg::TABLE_ENTRIES));
		sts.out_busy  = out_valid_q && !out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_found  = out_found_q;
	assign out_count  = out_count_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(rhh_pkg::TABLE_ENTRIES))
		else $error("entry count above table size");
	a_place_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place_new |-> count_q < CW'(rhh_pkg::TABLE_ENTRIES))
		else $error("new entry placed into a full table");
	a_no_req_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_req |-> !clr_busy_q)
		else $error("request taken during clearing pass");

endmodule

### rtl/rhh_ctrl.sv
// Controller state machine: sequences hash, search, insert placement,
// backward-shift erase and the response.
// Depends on rhh_pkg.
module rhh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rhh_pkg::rhh_sts_t sts,
	output rhh_pkg::rhh_cmd_t cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_HASH     = 4'd1;
	localparam logic [3:0] S_FIND_RD  = 4'd2;
	localparam logic [3:0] S_FIND_EV  = 4'd3;
	localparam logic [3:0] S_PLACE_RD = 4'd4;
	localparam logic [3:0] S_PLACE_EV = 4'd5;
	localparam logic [3:0] S_SHIFT_RD = 4'd6;
	localparam logic [3:0] S_SHIFT_EV = 4'd7;
	localparam logic [3:0] S_RESP     = 4'd8;

	logic [3:0] state_q, state_d;
	logic [2:0] resp_q, resp_d;
	logic       miss, hit;

	assign in_ready = (state_q == S_IDLE) && !sts.clr_busy;

	always_comb begin
		state_d      = state_q;
		resp_d       = resp_q;
		cmd          = '0;
		miss         = 1'b0;
		hit          = 1'b0;
		cmd.load_req = in_valid && in_ready;

		unique case (state_q)
			S_IDLE: begin
				if (cmd.load_req)
					state_d = S_HASH;
			end
			S_HASH: begin
				if (sts.hash_done) begin
					cmd.init_walk = 1'b1;
					if (sts.kind == rhh_pkg::KIND_NONE) begin
						resp_d  = rhh_pkg::RSP_ABSENT;
						state_d = S_RESP;
					end else begin
						state_d = S_FIND_RD;
					end
				end
			end
			S_FIND_RD: begin
				if (sts.step_full) begin
					miss = 1'b1;
				end else begin
					cmd.mem_rd = 1'b1;
					state_d    = S_FIND_EV;
				end
			end
			S_FIND_EV: begin
				if (!sts.rd_valid)
					miss = 1'b1;
				else if (sts.key_eq)
					hit = 1'b1;
				else if (sts.dist_lt)
					miss = 1'b1;
				else begin
					cmd.walk_adv = 1'b1;
					state_d      = S_FIND_RD;
				end
			end
			S_PLACE_RD: begin
				if (sts.step_full) begin
					resp_d  = rhh_pkg::RSP_INSERTED;
					state_d = S_RESP;
				end else begin
					cmd.mem_rd = 1'b1;
					state_d    = S_PLACE_EV;
				end
			end
			S_PLACE_EV: begin
				state_d = S_PLACE_RD;
				if (!sts.rd_valid) begin
					cmd.place_new = 1'b1;
					resp_d        = rhh_pkg::RSP_INSERTED;
					state_d       = S_RESP;
				end else if (sts.dist_lt) begin
					cmd.place_swap = 1'b1;
				end else begin
					cmd.walk_adv = 1'b1;
				end
			end
			S_SHIFT_RD: begin
				if (sts.step_last) begin
					cmd.shift_clear = 1'b1;
					resp_d          = rhh_pkg::RSP_ERASED;
					state_d         = S_RESP;
				end else begin
					cmd.mem_rd  = 1'b1;
					cmd.rd_next = 1'b1;
					state_d     = S_SHIFT_EV;
				end
			end
			S_SHIFT_EV: begin
				if (!sts.rd_valid || sts.dist_zero) begin
					cmd.shift_clear = 1'b1;
					resp_d          = rhh_pkg::RSP_ERASED;
					state_d         = S_RESP;
				end else begin
					cmd.shift_move = 1'b1;
					state_d        = S_SHIFT_RD;
				end
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = resp_q;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// Search outcome, per request kind
		if (miss) begin
			state_d = S_RESP;
			resp_d  = rhh_pkg::RSP_ABSENT;
			if (sts.kind == rhh_pkg::KIND_INSERT) begin
				if (sts.at_limit) begin
					resp_d = rhh_pkg::RSP_FULL;
				end else begin
					cmd.init_walk = 1'b1;
					state_d       = S_PLACE_RD;
				end
			end
		end
		if (hit) begin
			state_d = S_RESP;
			if (sts.kind == rhh_pkg::KIND_INSERT) begin
				cmd.upd_wr = 1'b1;
				resp_d     = rhh_pkg::RSP_UPDATED;
			end else if (sts.kind == rhh_pkg::KIND_LOOKUP) begin
				cmd.set_found = 1'b1;
				resp_d        = rhh_pkg::RSP_FOUND;
			end else begin
				cmd.step_clr = 1'b1;
				state_d      = S_SHIFT_RD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			resp_q  <= rhh_pkg::RSP_ABSENT;
		end else begin
			state_q <= state_d;
			resp_q  <= resp_d;
		end
	end

	// Checks
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_HASH)
		else $error("accepted request did not start hashing");
	a_eval_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND_EV || state_q == S_PLACE_EV || state_q == S_SHIFT_EV)
		|-> $past(cmd.mem_rd))
		else $error("slot evaluated without a read");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy)
		else $error("result register overwritten");

endmodule

### rtl/robin_hood_hash_table.sv
// Robin Hood hash table top level: controller plus datapath.
// Depends on rhh_pkg, rhh_ctrl and rhh_datapath.
//
// Usage:
//   Requests enter on in_valid/in_ready with kind (insert, lookup, erase),
//   key and value. One response per request leaves on out_valid/out_ready
//   with status, found_value and entry_count.
//   entry_limit is written through cfg_valid/cfg_ready/cfg_data, always ready;
//   write it only while no request is in flight.
// Request sequence:
//   One request at a time. The XXH64 hash runs five 64-bit multiplies on
//   one 32x32 multiplier, then hands over the home slot. Every probe,
//   placement or shift step then takes a memory read and an evaluate, and
//   a final step loads the response. The next request is accepted from
//   the same cycle that out_valid rises.
// Reset:
//   After arst_n releases, a clearing pass writes all 1024 slots, one per
//   cycle; in_ready stays low until the pass ends. entry_limit resets to 768.
// Stalls:
//   A finished response waits in the output register until out_ready; the
//   next request is accepted meanwhile but cannot respond until it is taken.
module robin_hood_hash_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    kind,
	input  logic [rhh_pkg::KEY_W-1:0]     key,
	input  logic [rhh_pkg::VAL_W-1:0]     value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [rhh_pkg::VAL_W-1:0]     found_value,
	output logic [rhh_pkg::LIM_W-1:0]     entry_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rhh_pkg::LIM_W-1:0]     cfg_data
);

	rhh_pkg::rhh_cmd_t cmd;
	rhh_pkg::rhh_sts_t sts;

	assign cfg_ready = 1'b1;

	rhh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rhh_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_kind    (kind),
		.in_key     (key),
		.in_value   (value),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_status (status),
		.out_found  (found_value),
		.out_count  (entry_count)
	);

endmodule

### bench/testbench.sv
// Testbench for the Robin Hood hash table: directed and random requests, config phases.
// Predicts each response with its own table model; depends on rhh_pkg and
// robin_hood_hash_table.
`timescale 1ns / 100ps

module testbench;

	typedef enum logic [1:0] {OP_REQ, OP_CFG, OP_SYNC, OP_HOLD} op_e;
	typedef enum logic [1:0] {MODE_SEND_IDLE, MODE_RECV_IDLE, MODE_BUSY} mode_e;

	typedef struct {
		op_e         op;
		logic [1:0]  kind;
		logic [63:0] key;
		logic [63:0] value;
		mode_e       mode;
	} work_t;

	typedef struct {
		logic [2:0]  status;
		logic [63:0] found_value;
		logic [10:0] entry_count;
	} answer_t;

	localparam int SLOTS = 1024;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_CYCLES = 4;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [63:0] key;
	logic [63:0] value;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [63:0] found_value;
	logic [10:0] entry_count;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [10:0] cfg_data;

	robin_hood_hash_table dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .key(key), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found_value(found_value), .entry_count(entry_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Shadow table
	logic [63:0] sh_key [SLOTS];
	logic [63:0] sh_val [SLOTS];
	int          sh_dist [SLOTS];
	bit          sh_used [SLOTS];
	int          sh_count;
	int          sh_limit;

	work_t       pending_q[$];
	answer_t     answer_q[$];
	logic [63:0] cluster_keys[$];
	logic [63:0] fill_keys[$];
	int          fails;
	int          quiet_cnt;
	logic        hold_req;
	logic        hold_seen;
	int          hold_left;
	mode_e       cur_mode;

	function automatic logic [63:0] rotl(logic [63:0] x, int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	// XXH64 of the 8 key bytes, seed 0, masked to the table
	function automatic int home_of(logic [63:0] k);
		logic [63:0] h;
		logic [63:0] r;
		h = 64'h27D4EB2F165667C5 + 64'd8;
		r = k * 64'hC2B2AE3D27D4EB4F;
		r = rotl(r, 31) * 64'h9E3779B185EBCA87;
		h ^= r;
		h = rotl(h, 27) * 64'h9E3779B185EBCA87 + 64'h85EBCA77C2B2AE63;
		h ^= h >> 33;
		h *= 64'hC2B2AE3D27D4EB4F;
		h ^= h >> 29;
		h *= 64'h165667B19E3779F9;
		h ^= h >> 32;
		return int'(h[9:0]);
	endfunction

	// Probe with early stop on distance
	function automatic bit locate(logic [63:0] k, output int where);
		int pos;
		int d;
		pos = home_of(k);
		d = 0;
		where = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!sh_used[pos])
				return 0;
			if (sh_key[pos] == k) begin
				where = pos;
				return 1;
			end
			if (d > sh_dist[pos])
				return 0;
			pos = (pos + 1) % SLOTS;
			d++;
		end
		return 0;
	endfunction

	function automatic void place_entry(logic [63:0] k, logic [63:0] v);
		int pos;
		int d;
		logic [63:0] tk;
		logic [63:0] tv;
		int td;
		pos = home_of(k);
		d = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!sh_used[pos]) begin
				sh_key[pos] = k;
				sh_val[pos] = v;
				sh_dist[pos] = d;
				sh_used[pos] = 1;
				sh_count++;
				return;
			end
			// displace only strictly richer residents
			if (d > sh_dist[pos]) begin
				tk = sh_key[pos];
				tv = sh_val[pos];
				td = sh_dist[pos];
				sh_key[pos] = k;
				sh_val[pos] = v;
				sh_dist[pos] = d;
				k = tk;
				v = tv;
				d = td;
			end
			pos = (pos + 1) % SLOTS;
			d++;
		end
	endfunction

	// Backward shift deletion
	function automatic void remove_at(int cur);
		int nxt;
		for (int i = 0; i + 1 < SLOTS; i++) begin
			nxt = (cur + 1) % SLOTS;
			if (!sh_used[nxt] || sh_dist[nxt] == 0)
				break;
			sh_key[cur] = sh_key[nxt];
			sh_val[cur] = sh_val[nxt];
			sh_dist[cur] = sh_dist[nxt] - 1;
			cur = nxt;
		end
		sh_used[cur] = 0;
	endfunction

	function automatic answer_t apply_request(logic [1:0] kd, logic [63:0] k, logic [63:0] v);
		answer_t a;
		int pos;
		a.status = rhh_pkg::RSP_ABSENT;
		a.found_value = '0;
		case (kd)
			rhh_pkg::KIND_INSERT: begin
				if (locate(k, pos)) begin
					sh_val[pos] = v;
					a.status = rhh_pkg::RSP_UPDATED;
				end else if (sh_count >= sh_limit || sh_count >= SLOTS) begin
					a.status = rhh_pkg::RSP_FULL;
				end else begin
					place_entry(k, v);
					a.status = rhh_pkg::RSP_INSERTED;
				end
			end
			rhh_pkg::KIND_LOOKUP: begin
				if (locate(k, pos)) begin
					a.found_value = sh_val[pos];
					a.status = rhh_pkg::RSP_FOUND;
				end
			end
			rhh_pkg::KIND_ERASE: begin
				if (locate(k, pos)) begin
					remove_at(pos);
					if (sh_count > 0)
						sh_count--;
					a.status = rhh_pkg::RSP_ERASED;
				end
			end
			default: ;
		endcase
		a.entry_count = sh_count[10:0];
		return a;
	endfunction

	function automatic int send_idle_pct(mode_e m);
		return (m == MODE_SEND_IDLE) ? 22 : (m == MODE_RECV_IDLE) ? 79 : 0;
	endfunction

	function automatic int recv_idle_pct(mode_e m);
		return (m == MODE_SEND_IDLE) ? 79 : (m == MODE_RECV_IDLE) ? 22 : 0;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic add_req(logic [1:0] kd, logic [63:0] k, logic [63:0] v, mode_e m);
		pending_q.push_back('{OP_REQ, kd, k, v, m});
	endtask

	task automatic add_ctl(op_e op, logic [10:0] lim);
		pending_q.push_back('{op, rhh_pkg::KIND_NONE, '0, {53'd0, lim}, MODE_BUSY});
	endtask

	// Random requests, mostly on a clustered key set so chains grow long
	task automatic add_random(int n, mode_e m);
		int r;
		logic [63:0] k;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			k = ($urandom_range(99) < 85) ?
				cluster_keys[$urandom_range(cluster_keys.size() - 1)] : rand64();
			if (r < 45)
				add_req(rhh_pkg::KIND_INSERT, k, rand64(), m);
			else if (r < 70)
				add_req(rhh_pkg::KIND_LOOKUP, k, rand64(), m);
			else if (r < 95)
				add_req(rhh_pkg::KIND_ERASE, k, rand64(), m);
			else
				add_req(rhh_pkg::KIND_NONE, k, rand64(), m);
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Driver: requests, register writes, pauses and hold-off triggers
	always @(posedge clk or negedge arst_n) begin
		work_t hd;
		bit go_req;
		bit go_cfg;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= rhh_pkg::KIND_NONE;
			key <= '0;
			value <= '0;
			cfg_valid <= 1'b0;
			cfg_data <= '0;
			hold_req <= 1'b0;
			cur_mode <= MODE_BUSY;
			quiet_cnt = 0;
			sh_count = 0;
			sh_limit = int'(rhh_pkg::LIMIT_RESET);
			for (int i = 0; i < SLOTS; i++)
				sh_used[i] = 0;
		end else begin
			go_req = in_valid;
			go_cfg = cfg_valid;
			if (in_valid && in_ready) begin
				answer_q.push_back(apply_request(pending_q[0].kind, pending_q[0].key,
					pending_q[0].value));
				void'(pending_q.pop_front());
				go_req = 0;
			end
			if (cfg_valid && cfg_ready) begin
				sh_limit = int'(cfg_data);
				void'(pending_q.pop_front());
				go_cfg = 0;
			end
			quiet_cnt = (answer_q.size() == 0) ? quiet_cnt + 1 : 0;
			if (!go_req && !go_cfg && pending_q.size() > 0) begin
				hd = pending_q[0];
				case (hd.op)
					OP_REQ: begin
						cur_mode <= hd.mode;
						if ($urandom_range(99) >= send_idle_pct(hd.mode)) begin
							go_req = 1;
							kind <= hd.kind;
							key <= hd.key;
							value <= hd.value;
						end
					end
					OP_CFG: begin
						if (quiet_cnt >= QUIET_CYCLES) begin
							go_cfg = 1;
							cfg_data <= hd.value[10:0];
						end
					end
					OP_SYNC: begin
						if (quiet_cnt >= QUIET_CYCLES)
							void'(pending_q.pop_front());
					end
					default: begin
						hold_req <= !hold_req;
						void'(pending_q.pop_front());
					end
				endcase
			end
			in_valid <= go_req;
			cfg_valid <= go_cfg;
		end
	end

	// Monitor: response checks and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_seen = 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answer_q.size() == 0) begin
					$error("response with no request outstanding: status %0d", status);
					fails++;
				end else begin
					want = answer_q.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fails++;
					end
					if (found_value !== want.found_value) begin
						$error("found_value: expected %h, actual %h",
							want.found_value, found_value);
						fails++;
					end
					if (entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, actual %0d",
							want.entry_count, entry_count);
						fails++;
					end
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct(cur_mode));
			end
		end
	end

	// Stimulus and end of run
	initial begin
		logic [63:0] k;
		fails = 0;
		arst_n = 1'b1;

		// keys that share a few home slots
		while (cluster_keys.size() < 40) begin
			k = rand64();
			if (home_of(k) < 16)
				cluster_keys.push_back(k);
		end
		cluster_keys.push_back('0);
		cluster_keys.push_back('1);

		// Directed: extremes, every kind, update, erase miss, unused kind
		add_ctl(OP_CFG, 11'd768);
		add_req(rhh_pkg::KIND_INSERT, '0, '0, MODE_BUSY);
		add_req(rhh_pkg::KIND_INSERT, '1, '1, MODE_BUSY);
		add_req(rhh_pkg::KIND_LOOKUP, '0, '1, MODE_BUSY);
		add_req(rhh_pkg::KIND_LOOKUP, '1, '0, MODE_BUSY);
		add_req(rhh_pkg::KIND_INSERT, '0, 64'h5, MODE_BUSY);
		add_req(rhh_pkg::KIND_LOOKUP, '0, '0, MODE_BUSY);
		add_req(rhh_pkg::KIND_ERASE, '0, '0, MODE_BUSY);
		add_req(rhh_pkg::KIND_ERASE, '0, '0, MODE_BUSY);
		add_req(rhh_pkg::KIND_LOOKUP, '0, '0, MODE_BUSY);
		add_req(rhh_pkg::KIND_NONE, '1, '1, MODE_BUSY);
		// displacement in one cluster, then shift on erase
		for (int i = 0; i < 6; i++)
			add_req(rhh_pkg::KIND_INSERT, cluster_keys[i], rand64(), MODE_BUSY);
		add_req(rhh_pkg::KIND_LOOKUP, cluster_keys[3], '0, MODE_BUSY);
		add_req(rhh_pkg::KIND_ERASE, cluster_keys[1], '0, MODE_BUSY);
		add_req(rhh_pkg::KIND_LOOKUP, cluster_keys[4], '0, MODE_BUSY);
		add_req(rhh_pkg::KIND_LOOKUP, cluster_keys[2], '0, MODE_BUSY);
		// limit zero: new key rejected, update still allowed
		add_ctl(OP_CFG, 11'd0);
		add_req(rhh_pkg::KIND_INSERT, cluster_keys[7], '1, MODE_BUSY);
		add_req(rhh_pkg::KIND_INSERT, '1, 64'h1234, MODE_BUSY);
		// limit reached exactly
		add_ctl(OP_CFG, 11'd7);
		add_req(rhh_pkg::KIND_INSERT, cluster_keys[8], rand64(), MODE_BUSY);
		add_req(rhh_pkg::KIND_INSERT, cluster_keys[9], rand64(), MODE_BUSY);
		add_ctl(OP_CFG, 11'd768);

		// Random phases with changing idling and limits
		add_random(100, MODE_SEND_IDLE);
		add_ctl(OP_HOLD, '0);
		add_random(100, MODE_SEND_IDLE);
		add_ctl(OP_SYNC, '0);
		add_ctl(OP_CFG, 11'd20);
		add_random(180, MODE_RECV_IDLE);
		add_ctl(OP_CFG, 11'd1024);
		add_random(80, MODE_BUSY);
		add_ctl(OP_HOLD, '0);
		add_random(80, MODE_BUSY);

		// Burst of fresh keys, then drain them
		add_ctl(OP_CFG, 11'd2047);
		for (int i = 0; i < 40; i++) begin
			k = rand64();
			fill_keys.push_back(k);
			add_req(rhh_pkg::KIND_INSERT, k, rand64(), MODE_BUSY);
		end
		add_req(rhh_pkg::KIND_LOOKUP, rand64(), '0, MODE_BUSY);
		add_req(rhh_pkg::KIND_LOOKUP, fill_keys[20], '0, MODE_BUSY);
		for (int i = fill_keys.size() - 1; i >= 0; i--)
			add_req(rhh_pkg::KIND_ERASE, fill_keys[i], '0, MODE_BUSY);

		#1 arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || answer_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#40000000;
		$display("Verification failed");
		$finish;
	end

endmodule

### files.f
rtl/rhh_pkg.sv
rtl/rhh_hash.sv
rtl/rhh_datapath.sv
rtl/rhh_ctrl.sv
rtl/robin_hood_hash_table.sv
bench/testbench.sv
